// File: rtl/oaht_pkg.sv
// Shared types, codes and constants for the open-addressing hash table.
// No dependencies; imported by oaht_ctrl, oaht_dp and the top level.
`default_nettype none
package oaht_pkg;

  localparam int unsigned MaxCapacity = 1024;
  localparam int unsigned MinCapacity = 8;

  // Load band: live*LoadScale must lie within [cap*LoadLow, cap*LoadHigh]
  localparam int unsigned LoadScale = 1024;
  localparam int unsigned LoadLow   = 256;
  localparam int unsigned LoadHigh  = 768;

  typedef enum logic [1:0] {
    SLOT_UNUSED = 2'd0,
    SLOT_TOMB   = 2'd1,
    SLOT_LIVE   = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_CLR_SLOT,
    DP_PRB_ADV,
    DP_LOOKUP_HIT,
    DP_REMOVE,
    DP_UPDATE,
    DP_FILL_TOMB,
    DP_FILL_FREE,
    DP_FULL,
    DP_TGT_INIT,
    DP_TGT_STEP,
    DP_RH_RD,
    DP_RH_WR,
    DP_RI_START,
    DP_RI_FILL,
    DP_RI_NEXT,
    DP_RH_FINISH,
    DP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_CLR,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_TGT,
    ST_RH_RD,
    ST_RH_WR,
    ST_RI_RD,
    ST_RI_CHK,
    ST_RI_PRD,
    ST_RI_PCHK,
    ST_RI_NXT,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic   in_ready;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    mode_e in_mode;
    mode_e mode;
    logic  slot_unused;
    logic  slot_match;
    logic  tomb_seen;
    logic  last_step;
    logic  grow;
    logic  tgt_done;
    logic  tgt_over;
    logic  copy_last;
    logic  ri_last;
    logic  clr_last;
    logic  scr_live;
    logic  out_free;
  } sts_t;

  // Identity hash, keys 0 and 1 map to 2
  function automatic logic [31:0] slot_hash(input logic [31:0] k);
    logic [31:0] h;
    h = (k < 32'd2) ? 32'd2 : k;
    return h;
  endfunction

endpackage
`default_nettype wire

// File: rtl/oaht_ctrl.sv
// Sequencer for probes, clears and rehash passes of the hash table.
// Depends on oaht_pkg; drives oaht_dp through cmd_t, reads sts_t.
`default_nettype none
module oaht_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire oaht_pkg::sts_t sts_i,
  output oaht_pkg::cmd_t     cmd_o
);
  import oaht_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.in_ready  = 1'b0;
    cmd_o.op        = DP_NONE;
    case (state_q)
      ST_RST_CLR: begin
        cmd_o.op = DP_CLR_SLOT;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.op = DP_ACCEPT;
          state_d  = (sts_i.in_mode == MODE_CLEAR) ? ST_CLR : ST_PRB_RD;
        end
      end
      ST_CLR: begin
        cmd_o.op = DP_CLR_SLOT;
        if (sts_i.clr_last) state_d = ST_RESP;
      end
      ST_PRB_RD: state_d = ST_PRB_CHK;
      ST_PRB_CHK: begin
        state_d = ST_RESP;
        if (sts_i.slot_match) begin
          case (sts_i.mode)
            MODE_LOOKUP: cmd_o.op = DP_LOOKUP_HIT;
            MODE_REMOVE: cmd_o.op = DP_REMOVE;
            MODE_INSERT: cmd_o.op = DP_UPDATE;
            default:     cmd_o.op = DP_NONE;
          endcase
        end else if (sts_i.slot_unused) begin
          if (sts_i.mode == MODE_INSERT) begin
            if (sts_i.tomb_seen) begin
              cmd_o.op = DP_FILL_TOMB;
            end else if (sts_i.grow) begin
              cmd_o.op = DP_TGT_INIT;
              state_d  = ST_TGT;
            end else begin
              cmd_o.op = DP_FILL_FREE;
            end
          end
        end else if (sts_i.last_step) begin
          cmd_o.op = DP_FULL;
        end else begin
          cmd_o.op = DP_PRB_ADV;
          state_d  = ST_PRB_RD;
        end
      end
      ST_TGT: begin
        if (!sts_i.tgt_done) begin
          cmd_o.op = DP_TGT_STEP;
        end else if (sts_i.tgt_over) begin
          cmd_o.op = DP_FULL;
          state_d  = ST_RESP;
        end else begin
          cmd_o.op = DP_FILL_FREE;
          state_d  = ST_RH_RD;
        end
      end
      ST_RH_RD: begin
        cmd_o.op = DP_RH_RD;
        state_d  = ST_RH_WR;
      end
      ST_RH_WR: begin
        cmd_o.op = DP_RH_WR;
        state_d  = sts_i.copy_last ? ST_RI_RD : ST_RH_RD;
      end
      ST_RI_RD: state_d = ST_RI_CHK;
      ST_RI_CHK: begin
        if (sts_i.scr_live) begin
          cmd_o.op = DP_RI_START;
          state_d  = ST_RI_PRD;
        end else begin
          state_d = ST_RI_NXT;
        end
      end
      ST_RI_PRD: state_d = ST_RI_PCHK;
      ST_RI_PCHK: begin
        if (sts_i.slot_unused) begin
          cmd_o.op = DP_RI_FILL;
          state_d  = ST_RI_NXT;
        end else begin
          cmd_o.op = DP_PRB_ADV;
          state_d  = ST_RI_PRD;
        end
      end
      ST_RI_NXT: begin
        if (sts_i.ri_last) begin
          cmd_o.op = DP_RH_FINISH;
          state_d  = ST_RESP;
        end else begin
          cmd_o.op = DP_RI_NEXT;
          state_d  = ST_RI_RD;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_OUT_LOAD;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/oaht_dp.sv
// Datapath: slot memories, rehash scratch memory, probe and count registers,
// output register. Depends on oaht_pkg; steered by oaht_ctrl.
`default_nettype none
module oaht_dp #(
  parameter int unsigned MAX_CAPACITY = oaht_pkg::MaxCapacity,
  parameter int unsigned MIN_CAPACITY = oaht_pkg::MinCapacity
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire oaht_pkg::cmd_t cmd_i,
  output oaht_pkg::sts_t      sts_o,
  input  wire logic           s_axis_tvalid_i,
  input  wire logic [63:0]    s_axis_tdata_i,
  input  wire logic [1:0]     s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [55:0]         m_axis_tdata_o
);
  import oaht_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_CAPACITY);
  localparam int unsigned CapW = AW + 1;
  localparam int unsigned NcW  = CapW + 1;
  localparam int unsigned LW   = CapW + 11;

  // memories
  logic [1:0]  st_mem  [MAX_CAPACITY];
  logic [31:0] key_mem [MAX_CAPACITY];
  logic [31:0] val_mem [MAX_CAPACITY];
  logic [64:0] scr_mem [MAX_CAPACITY];

  logic [1:0]  rd_state_q;
  logic [31:0] rd_key_q, rd_val_q;
  logic [64:0] scr_q;

  // request and control registers
  mode_e       mode_q;
  logic [31:0] key_q, val_q;
  logic [AW-1:0] idx_q, tomb_q, ptr_q;
  logic [CapW-1:0] step_q, cap_q, oldcap_q, live_q, used_q;
  logic [NcW-1:0]  newcap_q;
  logic        tomb_seen_q;
  logic        found_q, status_q;
  logic [31:0] rdv_q;
  logic        m_valid_q;
  logic [55:0] m_data_q;

  logic [AW-1:0]   mask, rd_addr, idx_adv;
  logic [CapW-1:0] cnt;
  logic [NcW-1:0]  need;
  logic [NcW-1:0]  copy_span;
  logic [LW-1:0]   load, lim_lo, lim_hi;
  logic            st_we, kv_we, v_we;
  logic [AW-1:0]   st_waddr;
  logic [1:0]      st_wdata;
  logic [31:0]     kv_key, kv_val;
  logic [31:0]     in_hash, scr_hash;
  logic [CapW+10:0] cnt_ext, cap_ext;
  logic            copy_live;

  assign mask     = AW'(cap_q - CapW'(1));
  assign in_hash  = slot_hash(s_axis_tdata_i[31:0]);
  assign scr_hash = slot_hash(scr_q[63:32]);
  assign idx_adv  = AW'(CapW'(idx_q) + step_q + CapW'(1)) & mask;
  assign rd_addr  = (cmd_i.op == DP_RH_RD) ? ptr_q : idx_q;

  assign cnt    = live_q + CapW'(1);
  assign need   = NcW'(cnt) << 1;
  assign load   = LW'(cnt) * LW'(LoadScale);
  assign lim_lo = LW'(cap_q) * LW'(LoadLow);
  assign lim_hi = LW'(cap_q) * LW'(LoadHigh);
  assign copy_live = (rd_state_q == SLOT_LIVE) && ({1'b0, ptr_q} < oldcap_q);
  // copy pass covers the old table and wipes the new one, whichever is larger
  assign copy_span = (NcW'(oldcap_q) > newcap_q) ? NcW'(oldcap_q) : newcap_q;

  // memory write decode
  always_comb begin
    st_we    = 1'b0;
    kv_we    = 1'b0;
    v_we     = 1'b0;
    st_waddr = idx_q;
    st_wdata = SLOT_UNUSED;
    kv_key   = key_q;
    kv_val   = val_q;
    case (cmd_i.op)
      DP_CLR_SLOT, DP_RH_WR: begin
        st_we    = 1'b1;
        st_waddr = ptr_q;
      end
      DP_REMOVE: begin
        st_we    = 1'b1;
        st_wdata = SLOT_TOMB;
      end
      DP_UPDATE: v_we = 1'b1;
      DP_FILL_TOMB: begin
        st_we    = 1'b1;
        kv_we    = 1'b1;
        st_waddr = tomb_q;
        st_wdata = SLOT_LIVE;
      end
      DP_FILL_FREE: begin
        st_we    = 1'b1;
        kv_we    = 1'b1;
        st_wdata = SLOT_LIVE;
      end
      DP_RI_FILL: begin
        st_we    = 1'b1;
        kv_we    = 1'b1;
        st_wdata = SLOT_LIVE;
        kv_key   = scr_q[63:32];
        kv_val   = scr_q[31:0];
      end
      default: st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (kv_we) key_mem[st_waddr] <= kv_key;
    if (kv_we || v_we) val_mem[st_waddr] <= kv_val;
    if (cmd_i.op == DP_RH_WR) scr_mem[ptr_q] <= {copy_live, rd_key_q, rd_val_q};
    rd_state_q <= st_mem[rd_addr];
    rd_key_q   <= key_mem[rd_addr];
    rd_val_q   <= val_mem[rd_addr];
    scr_q      <= scr_mem[ptr_q];
  end

  // request payload and result accumulators
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_ACCEPT: begin
        mode_q   <= mode_e'(s_axis_tuser_i);
        key_q    <= s_axis_tdata_i[31:0];
        val_q    <= s_axis_tdata_i[63:32];
        found_q  <= 1'b0;
        status_q <= 1'b0;
        rdv_q    <= '0;
      end
      DP_LOOKUP_HIT: begin
        found_q <= 1'b1;
        rdv_q   <= rd_val_q;
      end
      DP_REMOVE, DP_UPDATE: found_q <= 1'b1;
      DP_FULL:               status_q <= 1'b1;
      default:               found_q <= found_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      tomb_q      <= '0;
      ptr_q       <= '0;
      step_q      <= '0;
      cap_q       <= CapW'(MIN_CAPACITY);
      oldcap_q    <= CapW'(MIN_CAPACITY);
      newcap_q    <= NcW'(MIN_CAPACITY);
      live_q      <= '0;
      used_q      <= '0;
      tomb_seen_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_ACCEPT: begin
          idx_q       <= AW'(in_hash) & mask;
          step_q      <= '0;
          tomb_seen_q <= 1'b0;
          ptr_q       <= '0;
          if (s_axis_tuser_i == MODE_CLEAR) begin
            live_q <= '0;
            used_q <= '0;
          end
        end
        DP_CLR_SLOT, DP_RI_NEXT: ptr_q <= ptr_q + AW'(1);
        DP_PRB_ADV: begin
          if (rd_state_q == SLOT_TOMB && !tomb_seen_q) begin
            tomb_q      <= idx_q;
            tomb_seen_q <= 1'b1;
          end
          idx_q  <= idx_adv;
          step_q <= step_q + CapW'(1);
        end
        DP_REMOVE:    live_q <= live_q - CapW'(1);
        DP_FILL_TOMB: live_q <= cnt;
        DP_FILL_FREE: begin
          live_q   <= cnt;
          used_q   <= used_q + CapW'(1);
          oldcap_q <= cap_q;
          ptr_q    <= '0;
        end
        DP_TGT_INIT: newcap_q <= NcW'(MIN_CAPACITY);
        DP_TGT_STEP: newcap_q <= newcap_q << 1;
        DP_RH_WR: begin
          if (sts_o.copy_last) begin
            ptr_q <= '0;
            cap_q <= CapW'(newcap_q);
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        DP_RI_START: begin
          idx_q  <= AW'(scr_hash) & mask;
          step_q <= '0;
        end
        DP_RH_FINISH: used_q <= live_q;
        default:      ptr_q <= ptr_q;
      endcase
    end
  end

  // output register
  assign cnt_ext = {11'b0, live_q};
  assign cap_ext = {11'b0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_OUT_LOAD) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT_LOAD) begin
      m_data_q <= {cap_ext[10:0], cnt_ext[10:0], status_q, rdv_q, found_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // status to the controller
  assign sts_o.in_valid    = s_axis_tvalid_i;
  assign sts_o.in_mode     = mode_e'(s_axis_tuser_i);
  assign sts_o.mode        = mode_q;
  assign sts_o.slot_unused = (rd_state_q == SLOT_UNUSED);
  assign sts_o.slot_match  = (rd_state_q == SLOT_LIVE) && (rd_key_q == key_q);
  assign sts_o.tomb_seen   = tomb_seen_q;
  assign sts_o.last_step   = (step_q == cap_q - CapW'(1));
  assign sts_o.grow        = (load < lim_lo) || (load > lim_hi);
  assign sts_o.tgt_over    = (newcap_q > NcW'(MAX_CAPACITY));
  assign sts_o.tgt_done    = !((newcap_q < need) && !sts_o.tgt_over);
  assign sts_o.copy_last   = (ptr_q == AW'(copy_span - NcW'(1)));
  assign sts_o.ri_last     = (ptr_q == AW'(oldcap_q - CapW'(1)));
  assign sts_o.clr_last    = (ptr_q == mask);
  assign sts_o.scr_live    = scr_q[64];
  assign sts_o.out_free    = !m_valid_q || m_axis_tready_i;

endmodule
`default_nettype wire

// File: rtl/open_addressing_hash_table_core.sv
// Top level of the open-addressing hash table: sequencer plus datapath.
// Depends on oaht_pkg, oaht_ctrl and oaht_dp.
//
// Usage
//  - Request channel s_axis_*: tuser carries the operation (lookup, insert,
//    remove, clear), tdata the key (bits 31:0) and value (bits 63:32).
//  - Response channel m_axis_*: one response per request, in order.
//  - One request is in flight at a time. A lookup, remove or in-place insert
//    probes slot by slot; each probe step is one registered slot-memory read.
//  - Clear sweeps the slot-state memory, one slot per cycle.
//  - An insert that fills an unused slot and leaves the 25%..75% load band
//    rebuilds the table (or reports full if it would exceed MAX_CAPACITY): it
//    sizes the new table, copies the larger of the old and new tables into
//    scratch memory and wipes them, then re-places the live keys.
//  - After reset the block clears the first MIN_CAPACITY slots with tready
//    low; the table starts empty at MIN_CAPACITY slots.
//  - The response sits in an output register; while the receiver stalls the
//    next request is still accepted and worked on, and only its own
//    response waits for the register to drain.
`default_nettype none
module open_addressing_hash_table_core #(
  parameter int unsigned MAX_CAPACITY = oaht_pkg::MaxCapacity,
  parameter int unsigned MIN_CAPACITY = oaht_pkg::MinCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // key[31:0], value[63:32]
  input  wire logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // found[0], read_value[32:1], status[33], item_count[44:34],
  // table_capacity[55:45]
  output logic [55:0]      m_axis_tdata_o
);
  import oaht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oaht_dp #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .MIN_CAPACITY (MIN_CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // ready only while the sequencer waits for work
  assign s_axis_tready_o = cmd.in_ready;

endmodule
`default_nettype wire

// File: rtl/oaht_chk.sv
// Port-level checks of the hash table core, bound to the top level.
// Depends only on the ports of open_addressing_hash_table_core.
`default_nettype none
module oaht_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o
);

  // one request at a time: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted back to back");

  // a stalled response holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled response changed");

  // a failed request never reports a hit
  a_full_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33] |-> !m_axis_tdata_o[0])
    else $error("full status with found set");

  // a read value only comes with a hit
  a_rd_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[32:1] != 32'd0) |-> m_axis_tdata_o[0])
    else $error("read value without hit");

  // capacity is a power of two and live entries fit in it
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot(m_axis_tdata_o[55:45])
                        && (m_axis_tdata_o[44:34] <= m_axis_tdata_o[55:45]))
    else $error("bad capacity or item count");

endmodule

bind open_addressing_hash_table_core oaht_chk u_oaht_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
